// File: sv/ipsm_pkg.sv
// Shared types and constants for the IP-to-state map stream decoder.
package ipsm_pkg;

   // Error codes carried on the result channel.
   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_RESERVED   = 3'd1;
   localparam logic [2:0] ERR_OVERLONG   = 3'd2;
   localparam logic [2:0] ERR_EMPTY      = 3'd3;
   localparam logic [2:0] ERR_RECORDS    = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd5;
   localparam logic [2:0] ERR_STATE      = 3'd6;
   localparam logic [2:0] ERR_BYTES      = 3'd7;

   // Configuration register indexes.
   localparam logic CSR_MAX_RECORDS = 1'b0;
   localparam logic CSR_MAX_BYTES   = 1'b1;

   // Variable-length integer encoding.
   localparam logic [2:0]  LEN_LONG    = 3'd5;
   localparam logic [7:0]  LONG_PREFIX = 8'd15;
   localparam logic [31:0] MIN_LEN2    = 32'h0000_0080;
   localparam logic [31:0] MIN_LEN3    = 32'h0000_4000;
   localparam logic [31:0] MIN_LEN4    = 32'h0020_0000;
   localparam logic [31:0] MIN_LEN5    = 32'h1000_0000;
   localparam logic [31:0] STATE_LIMIT = 32'h8000_0000;

   // Reset values of the budget registers.
   localparam logic [31:0] MAX_RECORDS_RESET = 32'd65536;
   localparam logic [31:0] MAX_BYTES_RESET   = 32'd1048576;

   // One decoded event handed from the front end to the back end.
   typedef struct packed {
      logic        start;
      logic        budget;
      logic [2:0]  err;
      logic [31:0] value;
   } token_type;

   // One result handed from the back end to the response queue.
   typedef struct packed {
      logic [31:0] entry_index;
      logic [31:0] delta;
      logic [31:0] function_offset;
      logic [31:0] ip_state;
      logic [2:0]  error_code;
      logic        last;
   } result_type;

endpackage

// File: sv/ipsm_fifo.sv
// Small register-based first-in first-out queue.
module ipsm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/ipsm_front.sv
// Front end: byte budget accounting and variable-length integer assembly.
module ipsm_front
   import ipsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        map_start,
   input  logic [31:0] max_bytes,
   output logic        tok_valid,
   output token_type   tok
);

   logic [2:0]  seen_ff, seen_in;
   logic [2:0]  len_ff, len_in;
   logic [31:0] acc_ff, acc_in;
   logic        bad_ff, bad_in;
   logic [31:0] used_ff, used_in;
   logic        pend_ff, pend_in;

   always_comb begin
      logic        restart;
      logic [2:0]  seen_cur;
      logic [2:0]  len_cur;
      logic [31:0] acc_cur;
      logic        bad_cur;
      logic [31:0] used_cur;
      logic [2:0]  seen_new;
      logic [5:0]  shift;
      logic [31:0] minimum;

      // A map start clears all progress before the byte is used.
      restart  = accept & map_start;
      seen_cur = restart ? 3'd0  : seen_ff;
      len_cur  = restart ? 3'd0  : len_ff;
      acc_cur  = restart ? 32'd0 : acc_ff;
      bad_cur  = restart ? 1'b0  : bad_ff;
      used_cur = restart ? 32'd0 : used_ff;

      seen_new  = seen_cur;
      shift     = 6'd0;
      minimum   = 32'd0;
      seen_in   = seen_cur;
      len_in    = len_cur;
      acc_in    = acc_cur;
      bad_in    = bad_cur;
      used_in   = used_cur;
      tok_valid = 1'b0;
      tok.start  = map_start | pend_ff;
      tok.budget = 1'b0;
      tok.err    = ERR_OK;
      tok.value  = 32'd0;

      if (accept) begin
         if (used_cur >= max_bytes) begin
            // Budget exhausted: report without consuming the byte.
            tok_valid  = 1'b1;
            tok.budget = 1'b1;
         end else begin
            used_in = used_cur + 32'd1;
            if (seen_cur == 3'd0) begin
               // First byte: its low prefix bits select the length.
               priority if (data_byte[0] == 1'b0) begin
                  len_in = 3'd1;
               end else if (data_byte[1:0] == 2'b01) begin
                  len_in = 3'd2;
               end else if (data_byte[2:0] == 3'b011) begin
                  len_in = 3'd3;
               end else if (data_byte[3:0] == 4'b0111) begin
                  len_in = 3'd4;
               end else begin
                  len_in = LEN_LONG;
               end
               if (len_in == LEN_LONG) begin
                  acc_in = 32'd0;
                  bad_in = (data_byte != LONG_PREFIX);
               end else begin
                  acc_in = {24'd0, data_byte} >> len_in;
                  bad_in = 1'b0;
               end
               seen_new = 3'd1;
            end else begin
               // Later bytes are packed little-endian above the prefix.
               if (len_cur == LEN_LONG) begin
                  shift = {seen_cur - 3'd1, 3'b000};
               end else begin
                  shift = {seen_cur, 3'b000} - {3'b000, len_cur};
               end
               acc_in   = acc_cur | ({24'd0, data_byte} << shift);
               seen_new = seen_cur + 3'd1;
            end

            if (seen_new >= len_in) begin
               // Value complete: check the prefix and the overlong form.
               seen_in   = 3'd0;
               tok_valid = 1'b1;
               tok.value = acc_in;
               unique case (len_in)
                  3'd2:     minimum = MIN_LEN2;
                  3'd3:     minimum = MIN_LEN3;
                  3'd4:     minimum = MIN_LEN4;
                  LEN_LONG: minimum = MIN_LEN5;
                  default:  minimum = 32'd0;
               endcase
               if (bad_in) begin
                  tok.err = ERR_RESERVED;
               end else if (acc_in < minimum) begin
                  tok.err = ERR_OVERLONG;
               end
            end else begin
               seen_in = seen_new;
            end
         end
      end

      // A map start that produced no event rides on the next one.
      if (accept) begin
         pend_in = tok_valid ? 1'b0 : (map_start | pend_ff);
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 3'd0;
         len_ff  <= 3'd0;
         acc_ff  <= 32'd0;
         bad_ff  <= 1'b0;
         used_ff <= 32'd0;
         pend_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         bad_ff  <= bad_in;
         used_ff <= used_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: sv/ipsm_back.sv
// Back end: map structure sequencing, offset accumulation and result forming.
module ipsm_back
   import ipsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        tok_take,
   input  token_type   tok,
   input  logic [31:0] max_records,
   output logic        res_valid,
   output result_type  res
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_COUNT = 2'd1;
   localparam logic [1:0] PH_DELTA = 2'd2;
   localparam logic [1:0] PH_STATE = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic        halted_ff, halted_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] pdelta_ff, pdelta_in;
   logic [31:0] count_ff, count_in;

   always_comb begin
      logic [1:0]  phase_cur;
      logic        halted_cur;
      logic [31:0] left_cur;
      logic [31:0] offset_cur;
      logic [31:0] pdelta_cur;
      logic [31:0] count_cur;
      logic        fail;
      logic [2:0]  fail_code;

      // A map start clears the map progress.
      phase_cur  = tok.start ? PH_COUNT : phase_ff;
      halted_cur = tok.start ? 1'b0     : halted_ff;
      left_cur   = tok.start ? 32'd0    : left_ff;
      offset_cur = tok.start ? 32'd0    : offset_ff;
      pdelta_cur = tok.start ? 32'd0    : pdelta_ff;
      count_cur  = tok.start ? 32'd0    : count_ff;

      fail       = 1'b0;
      fail_code  = ERR_OK;
      phase_in   = phase_ff;
      halted_in  = halted_ff;
      left_in    = left_ff;
      offset_in  = offset_ff;
      pdelta_in  = pdelta_ff;
      count_in   = count_ff;
      res_valid  = 1'b0;
      res.entry_index     = count_cur;
      res.delta           = 32'd0;
      res.function_offset = 32'd0;
      res.ip_state        = 32'd0;
      res.error_code      = ERR_OK;
      res.last            = 1'b0;

      if (tok_take) begin
         phase_in  = phase_cur;
         halted_in = halted_cur;
         left_in   = left_cur;
         offset_in = offset_cur;
         pdelta_in = pdelta_cur;
         count_in  = count_cur;

         if (!halted_cur && phase_cur != PH_IDLE) begin
            if (tok.budget) begin
               fail      = 1'b1;
               fail_code = ERR_BYTES;
            end else begin
               unique case (phase_cur)
                  PH_COUNT: begin
                     if (tok.err != ERR_OK) begin
                        fail      = 1'b1;
                        fail_code = tok.err;
                     end else if (tok.value == 32'd0) begin
                        fail      = 1'b1;
                        fail_code = ERR_EMPTY;
                     end else if (tok.value > max_records) begin
                        fail      = 1'b1;
                        fail_code = ERR_RECORDS;
                     end else begin
                        left_in  = tok.value;
                        phase_in = PH_DELTA;
                     end
                  end
                  PH_DELTA: begin
                     if (tok.err != ERR_OK) begin
                        fail      = 1'b1;
                        fail_code = tok.err;
                     end else begin
                        pdelta_in = tok.value;
                        phase_in  = PH_STATE;
                     end
                  end
                  PH_STATE: begin
                     if (tok.err != ERR_OK) begin
                        fail      = 1'b1;
                        fail_code = tok.err;
                     end else if (pdelta_cur > ~offset_cur) begin
                        fail      = 1'b1;
                        fail_code = ERR_OVERFLOW;
                     end else if (tok.value > STATE_LIMIT) begin
                        fail      = 1'b1;
                        fail_code = ERR_STATE;
                     end else begin
                        // Completed pair: one result for the entry.
                        offset_in           = offset_cur + pdelta_cur;
                        res_valid           = 1'b1;
                        res.delta           = pdelta_cur;
                        res.function_offset = offset_in;
                        res.ip_state        = tok.value - 32'd1;
                        count_in            = count_cur + 32'd1;
                        left_in             = left_cur - 32'd1;
                        if (left_cur == 32'd1) begin
                           res.last  = 1'b1;
                           phase_in  = PH_IDLE;
                           halted_in = 1'b1;
                        end else begin
                           phase_in = PH_DELTA;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end

            // Any error gives one final result and halts the map.
            if (fail) begin
               res_valid      = 1'b1;
               res.error_code = fail_code;
               res.last       = 1'b1;
               phase_in       = PH_IDLE;
               halted_in      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         halted_ff <= 1'b1;
         left_ff   <= 32'd0;
         offset_ff <= 32'd0;
         pdelta_ff <= 32'd0;
         count_ff  <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
         left_ff   <= left_in;
         offset_ff <= offset_in;
         pdelta_ff <= pdelta_in;
         count_ff  <= count_in;
      end
   end

   // An error result always closes the map.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.error_code != ERR_OK) |-> res.last)
      else $error("error result without last");

   // After a final result the back end ignores events until a map start.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.last) |=> (halted_ff && phase_ff == PH_IDLE))
      else $error("back end not halted after final result");

   // A non-final entry advances the entry counter by one.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.last) |=> (count_ff == $past(res.entry_index) + 32'd1))
      else $error("entry counter did not advance");

   // Results appear only when an event is taken.
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> tok_take)
      else $error("result without an event");

endmodule

// File: sv/ip_state_map_stream_decoder_top.sv
// Top level of the IP-to-state map stream decoder.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         push / full               data_byte, map_start
//   rsp_      out        empty / pop               entry_index .. last
//   csr_      in         write_enable              index, write_data
//
// One byte is accepted per cycle, back to back, while req_full is low; each byte
// takes one pass through the varint front end, the event queue and the map back
// end. Events are held in the event queue, results in the response queue.
// Reset is synchronous: budgets return to their reset values and the decoder
// is halted until a byte with map_start. A full response queue stalls the
// back end, and a full event queue raises req_full.
module ip_state_map_stream_decoder_top
   import ipsm_pkg::*;
#(
   parameter int EVENT_DEPTH = 2,
   parameter int RESULT_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_map_start,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_entry_index,
   output logic [31:0]        rsp_delta,
   output logic [31:0]        rsp_function_offset,
   output logic signed [31:0] rsp_ip_state,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);

   logic [31:0] max_records_ff;
   logic [31:0] max_bytes_ff;
   logic        accept;
   logic        tok_valid;
   token_type   tok_push;
   token_type   tok_pop;
   logic        evt_empty;
   logic        tok_take;
   logic        res_valid;
   result_type  res_push;
   result_type  res_pop;
   logic        res_full;

   // Budget registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_records_ff <= MAX_RECORDS_RESET;
         max_bytes_ff   <= MAX_BYTES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_RECORDS: max_records_ff <= csr_write_data;
            CSR_MAX_BYTES:   max_bytes_ff   <= csr_write_data;
            default:         max_bytes_ff   <= max_bytes_ff;
         endcase
      end
   end

   assign accept = req_push & ~req_full;

   // Front end classifies each byte.
   ipsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .map_start (req_map_start),
      .max_bytes (max_bytes_ff),
      .tok_valid (tok_valid),
      .tok       (tok_push)
   );

   // Event queue between the two halves.
   ipsm_fifo #(
      .WIDTH ($bits(token_type)),
      .DEPTH (EVENT_DEPTH)
   ) u_event_q (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_valid),
      .push_data (tok_push),
      .full      (req_full),
      .pop       (tok_take),
      .pop_data  (tok_pop),
      .empty     (evt_empty)
   );

   assign tok_take = ~evt_empty & ~res_full;

   // Back end walks the map structure.
   ipsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .tok_take    (tok_take),
      .tok         (tok_pop),
      .max_records (max_records_ff),
      .res_valid   (res_valid),
      .res         (res_push)
   );

   // Response queue.
   ipsm_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_push),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_pop),
      .empty     (rsp_empty)
   );

   assign rsp_entry_index     = res_pop.entry_index;
   assign rsp_delta           = res_pop.delta;
   assign rsp_function_offset = res_pop.function_offset;
   assign rsp_ip_state        = $signed(res_pop.ip_state);
   assign rsp_error_code      = res_pop.error_code;
   assign rsp_last            = res_pop.last;

endmodule

// File: verif/ip_state_map_stream_decoder_top_test.sv
// Self-checking testbench for the IP-to-state map stream decoder.
module ip_state_map_stream_decoder_top_test;
   import ipsm_pkg::*;

   localparam int RANDOM_BYTES = 1200;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {MAP_IDLE, MAP_COUNT, MAP_DELTA, MAP_STATE} map_phase_type;
   typedef enum logic [1:0] {POP_ALWAYS, POP_MOSTLY, POP_HALF, POP_PERIODIC} pop_mode_type;

   typedef struct {
      logic [7:0] data;
      logic       start;
   } feed_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_data_byte = 8'd0;
   logic               req_map_start = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [31:0]        rsp_entry_index;
   logic [31:0]        rsp_delta;
   logic [31:0]        rsp_function_offset;
   logic signed [31:0] rsp_ip_state;
   logic [2:0]         rsp_error_code;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = CSR_MAX_RECORDS;
   logic [31:0]        csr_write_data = 32'd0;

   ip_state_map_stream_decoder_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_map_start      (req_map_start),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_delta          (rsp_delta),
      .rsp_function_offset(rsp_function_offset),
      .rsp_ip_state       (rsp_ip_state),
      .rsp_error_code     (rsp_error_code),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Stimulus and scoreboard storage.
   feed_item_type byte_feed[$];
   logic [7:0] map_image[$];
   result_type expected_results[$];

   // Decoder state mirrored by the predictor.
   map_phase_type map_phase = MAP_IDLE;
   logic [2:0]  vlen = 3'd0;
   logic [2:0]  vbytes = 3'd0;
   logic [31:0] vacc = 32'd0;
   logic [31:0] entries_left = 32'd0;
   logic [31:0] bytes_used = 32'd0;
   logic [31:0] offset_sum = 32'd0;
   logic [31:0] delta_held = 32'd0;
   logic [31:0] entry_count = 32'd0;
   logic        halted = 1'b1;
   logic        reserved_seen = 1'b0;
   logic [31:0] lim_records = MAX_RECORDS_RESET;
   logic [31:0] lim_bytes = MAX_BYTES_RESET;

   // Run statistics.
   int          cycle_count = 0;
   int          fail_count = 0;
   int          bytes_accepted = 0;
   int          bytes_queued = 0;
   int          results_checked = 0;
   int          error_results = 0;
   int          settings_applied = 0;
   logic [7:0]  codes_seen = 8'd0;

   // Driver and monitor pacing.
   int          burst_left = 0;
   int          gap_left = 0;
   int          pattern_left = 0;
   pop_mode_type pop_mode = POP_ALWAYS;
   feed_item_type next_item;
   result_type  want;
   result_type  got;

   // An error closes the map: the result carries the index of the entry in progress.
   task automatic expect_error(input logic [2:0] code);
      result_type r;
      r.entry_index = entry_count;
      r.delta = 32'd0;
      r.function_offset = 32'd0;
      r.ip_state = 32'd0;
      r.error_code = code;
      r.last = 1'b1;
      expected_results.insert(expected_results.size(), r);
      codes_seen[code] = 1'b1;
      halted = 1'b1;
      map_phase = MAP_IDLE;
   endtask

   // Predicts the effect of one accepted byte on the decoder.
   task automatic predict_map_byte(input logic [7:0] b, input logic start);
      logic [31:0] floor;
      logic [2:0]  code;
      int          shift;
      result_type  r;
      if (start) begin
         map_phase = MAP_COUNT;
         vlen = 3'd0;
         vbytes = 3'd0;
         vacc = 32'd0;
         entries_left = 32'd0;
         bytes_used = 32'd0;
         offset_sum = 32'd0;
         delta_held = 32'd0;
         entry_count = 32'd0;
         halted = 1'b0;
         reserved_seen = 1'b0;
      end
      if (halted || map_phase == MAP_IDLE) return;
      if (bytes_used >= lim_bytes) begin
         expect_error(ERR_BYTES);
         return;
      end
      bytes_used++;

      // Variable-length integer: the first byte picks the length by its low prefix bits.
      if (vbytes == 3'd0) begin
         if (!b[0]) vlen = 3'd1;
         else if (b[1:0] == 2'b01) vlen = 3'd2;
         else if (b[2:0] == 3'b011) vlen = 3'd3;
         else if (b[3:0] == 4'b0111) vlen = 3'd4;
         else vlen = LEN_LONG;
         if (vlen == LEN_LONG) begin
            vacc = 32'd0;
            reserved_seen = (b != LONG_PREFIX);
         end else begin
            vacc = 32'(b) >> vlen;
            reserved_seen = 1'b0;
         end
         vbytes = 3'd1;
      end else begin
         if (vlen == LEN_LONG) shift = 8 * (int'(vbytes) - 1);
         else shift = 8 * int'(vbytes) - int'(vlen);
         if (shift < 32) vacc = vacc | (32'(b) << shift);
         vbytes = vbytes + 3'd1;
      end
      if (vbytes < vlen) return;
      vbytes = 3'd0;
      case (vlen)
         3'd2: floor = MIN_LEN2;
         3'd3: floor = MIN_LEN3;
         3'd4: floor = MIN_LEN4;
         LEN_LONG: floor = MIN_LEN5;
         default: floor = 32'd0;
      endcase
      if (reserved_seen) code = ERR_RESERVED;
      else if (vacc < floor) code = ERR_OVERLONG;
      else code = ERR_OK;

      // Map structure: count, then delta and state pairs.
      case (map_phase)
         MAP_COUNT: begin
            if (code != ERR_OK) expect_error(code);
            else if (vacc == 32'd0) expect_error(ERR_EMPTY);
            else if (vacc > lim_records) expect_error(ERR_RECORDS);
            else begin
               entries_left = vacc;
               map_phase = MAP_DELTA;
            end
         end
         MAP_DELTA: begin
            if (code != ERR_OK) expect_error(code);
            else begin
               delta_held = vacc;
               map_phase = MAP_STATE;
            end
         end
         default: begin
            if (code != ERR_OK) expect_error(code);
            else if (delta_held > 32'hFFFF_FFFF - offset_sum) expect_error(ERR_OVERFLOW);
            else if (vacc > STATE_LIMIT) expect_error(ERR_STATE);
            else begin
               offset_sum = offset_sum + delta_held;
               r.entry_index = entry_count;
               r.delta = delta_held;
               r.function_offset = offset_sum;
               r.ip_state = (vacc == 32'd0) ? 32'hFFFF_FFFF : vacc - 32'd1;
               r.error_code = ERR_OK;
               entry_count++;
               entries_left--;
               r.last = (entries_left == 32'd0);
               if (r.last) begin
                  map_phase = MAP_IDLE;
                  halted = 1'b1;
               end else begin
                  map_phase = MAP_DELTA;
               end
               expected_results.insert(expected_results.size(), r);
            end
         end
      endcase
   endtask

   // Stimulus building.
   task automatic queue_byte(input logic [7:0] data, input logic start);
      feed_item_type item;
      item.data = data;
      item.start = start;
      byte_feed.insert(byte_feed.size(), item);
      bytes_queued++;
   endtask

   // Encodes one value at the given length; a bad prefix only applies to the long form.
   task automatic encode_value(input logic [31:0] v, input int len, input bit bad_prefix);
      logic [39:0] word;
      if (len == int'(LEN_LONG)) begin
         map_image.insert(map_image.size(),
                          bad_prefix ? {4'($urandom_range(1, 15)), 4'hF} : LONG_PREFIX);
         for (int i = 0; i < 4; i++) map_image.insert(map_image.size(), v[8*i +: 8]);
      end else begin
         word = ({8'd0, v} << len) | ((40'd1 << (len - 1)) - 40'd1);
         for (int i = 0; i < len; i++) map_image.insert(map_image.size(), word[8*i +: 8]);
      end
   endtask

   // Mostly the shortest form, with occasional overlong and reserved-prefix forms.
   task automatic put_value(input logic [31:0] v);
      int shortest;
      int roll;
      shortest = (v < MIN_LEN2) ? 1 : (v < MIN_LEN3) ? 2 : (v < MIN_LEN4) ? 3 :
                 (v < MIN_LEN5) ? 4 : 5;
      roll = $urandom_range(0, 99);
      if (roll < 3 && shortest < 5) encode_value(v, $urandom_range(shortest + 1, 5), 1'b0);
      else if (roll < 5) encode_value(v, int'(LEN_LONG), 1'b1);
      else encode_value(v, shortest, 1'b0);
   endtask

   // Moves the built map into the request feed, flagging its first byte as a map start.
   task automatic send_map();
      for (int i = 0; i < map_image.size(); i++) queue_byte(map_image[i], i == 0);
      map_image.delete();
   endtask

   function automatic logic [31:0] random_value(input int small_max, input int wide_pct);
      logic [31:0] edges[14] = '{32'd0, 32'd1, 32'd127, 32'd128, 32'd16383, 32'd16384,
                                 32'h001F_FFFF, 32'h0020_0000, 32'h0FFF_FFFF, 32'h1000_0000,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF};
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < wide_pct) return $urandom;
      if (roll < wide_pct + 15) return edges[$urandom_range(0, 13)];
      return $urandom_range(0, small_max);
   endfunction

   // One map, usually well formed; sometimes a bad count, a cut-off tail or stray bytes.
   task automatic queue_random_map();
      int          pairs;
      int          roll;
      int          keep;
      logic [31:0] count;
      roll = $urandom_range(0, 99);
      pairs = $urandom_range(1, (lim_records < 32'd6) ? int'(lim_records) : 6);
      count = pairs;
      if (roll < 3) count = 32'd0;
      else if (roll < 6) count = (lim_records == 32'hFFFF_FFFF) ? $urandom : lim_records + 1;
      put_value(count);
      for (int p = 0; p < pairs; p++) begin
         put_value(random_value(1000, 4));
         put_value(random_value(300, 4));
      end
      if (roll >= 94) begin
         keep = $urandom_range(1, map_image.size());
         while (map_image.size() > keep) void'(map_image.pop_back());
      end
      send_map();
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 49) == 0) queue_byte(8'($urandom), 1'b1);
   endtask

   task automatic queue_random_traffic(input int count);
      int target;
      target = bytes_queued + count;
      while (bytes_queued < target) queue_random_map();
   endtask

   // Waits until every request has gone in and every expected result has come out.
   task automatic settle();
      do @(negedge clock);
      while (byte_feed.size() != 0 || req_push || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MAX_RECORDS) lim_records = value;
      else lim_bytes = value;
   endtask

   task automatic apply_limits(input logic [31:0] records, input logic [31:0] budget);
      settle();
      write_reg(CSR_MAX_RECORDS, records);
      write_reg(CSR_MAX_BYTES, budget);
      settings_applied++;
      @(negedge clock);
   endtask

   // Driver: sends requests from the feed in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_push && !req_full) begin
            predict_map_byte(req_data_byte, req_map_start);
            bytes_accepted++;
         end
         if (req_push && req_full) begin
            // The request stays on the ports until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (byte_feed.size() != 0) begin
            next_item = byte_feed.pop_front();
            req_push <= 1'b1;
            req_data_byte <= next_item.data;
            req_map_start <= next_item.start;
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Monitor: takes results under a changing stall pattern and checks them in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_entry_index, rsp_delta, rsp_function_offset, rsp_ip_state,
                   rsp_error_code, rsp_last};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("Unexpected result: index %0d err %0d last %0d",
                           got.entry_index, got.error_code, got.last);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (want.error_code != ERR_OK) error_results++;
               if (got.entry_index !== want.entry_index || got.delta !== want.delta ||
                   got.function_offset !== want.function_offset ||
                   got.ip_state !== want.ip_state || got.error_code !== want.error_code ||
                   got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("Mismatch at result %0d", results_checked);
                     $display("  expected index %0d delta %h offset %h state %0d err %0d last %0d",
                              want.entry_index, want.delta, want.function_offset,
                              $signed(want.ip_state), want.error_code, want.last);
                     $display("  actual   index %0d delta %h offset %h state %0d err %0d last %0d",
                              got.entry_index, got.delta, got.function_offset,
                              $signed(got.ip_state), got.error_code, got.last);
                  end
               end
            end
         end
         if (pattern_left == 0) begin
            pop_mode = pop_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(8, 64);
         end else begin
            pattern_left--;
         end
         case (pop_mode)
            POP_ALWAYS: rsp_pop <= 1'b1;
            POP_MOSTLY: rsp_pop <= ($urandom_range(0, 3) != 0);
            POP_HALF: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= (cycle_count % 16 >= 12);
         endcase
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed maps under the reset budgets.
      queue_byte(8'hFF, 1'b0);               // halted after reset: ignored
      encode_value(32'd1, 1, 1'b0);          // one entry, zero delta, state zero
      encode_value(32'd0, 1, 1'b0);
      encode_value(32'd0, 1, 1'b0);
      send_map();
      queue_byte(8'h00, 1'b0);               // idle after the map end: ignored
      encode_value(32'd2, 2, 1'b0);          // overlong count
      send_map();
      encode_value(32'd0, 1, 1'b0);          // empty map
      send_map();
      encode_value(32'd70000, 3, 1'b0);      // count above the record budget
      send_map();
      encode_value(32'd2, 1, 1'b0);          // full-range delta, then overflow beats state range
      encode_value(32'hFFFF_FFFF, 5, 1'b0);
      encode_value(32'd0, 1, 1'b0);
      encode_value(32'd1, 1, 1'b0);
      encode_value(32'h8000_0001, 5, 1'b0);
      send_map();
      encode_value(32'd123, 5, 1'b1);        // reserved long-form prefix
      send_map();

      // Random maps under a series of budget settings, extremes included.
      queue_random_traffic(RANDOM_BYTES / 6);
      apply_limits(32'd3, 32'd24);
      queue_random_traffic(RANDOM_BYTES / 6);
      apply_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_random_traffic(RANDOM_BYTES / 6);
      apply_limits(32'd1, 32'd1);
      queue_random_traffic(RANDOM_BYTES / 12);
      apply_limits($urandom_range(1, 8), $urandom_range(10, 120));
      queue_random_traffic(RANDOM_BYTES / 6);
      apply_limits($urandom_range(2, 16), $urandom_range(4000, 100000));
      queue_random_traffic(RANDOM_BYTES / 6);
      apply_limits(MAX_RECORDS_RESET, MAX_BYTES_RESET);
      queue_random_traffic(RANDOM_BYTES / 12);
      settle();

      $display("Run summary: %0d requests accepted, %0d results checked, %0d of them errors.",
               bytes_accepted, results_checked, error_results);
      $display("Error codes produced (bit per code): %b; budget settings written: %0d.",
               codes_seen, settings_applied);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d failures", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
